@@ sv/urbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared constants, request codes, types and index helpers for the uart
// ring buffer echo core.
// ----------------------------------------------------------------------------
package urbe_pkg;

  // ring sizes and index widths
  localparam int TX_DEPTH = 256;
  localparam int RX_DEPTH = 256;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int BYTE_W   = 8;

  // escape byte, never echoed
  localparam logic [BYTE_W-1:0] ESC_CODE = 8'd27;

  // request kinds
  localparam logic [1:0] REQ_RX_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TX_EMPTY = 2'd1;
  localparam logic [1:0] REQ_POLL     = 2'd2;
  localparam logic [1:0] REQ_PUT      = 2'd3;

  // one result word
  typedef struct packed {
    logic              tx_active;
    logic              rx_nonempty;
    logic              accepted;
    logic [BYTE_W-1:0] deliver_byte;
    logic              deliver_valid;
    logic [BYTE_W-1:0] line_byte;
    logic              line_valid;
  } result_t;

  // ring memory port requests
  typedef struct packed {
    logic              we;
    logic [TX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [TX_AW-1:0]  raddr;
  } tx_mem_req_t;

  typedef struct packed {
    logic              we;
    logic [RX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [RX_AW-1:0]  raddr;
  } rx_mem_req_t;

  // ring index increment with wrap
  function automatic logic [TX_AW-1:0] next_tx(input logic [TX_AW-1:0] i);
    if (i == TX_AW'(TX_DEPTH - 1)) begin
      return '0;
    end else begin
      return i + 1'b1;
    end
  endfunction

  function automatic logic [RX_AW-1:0] next_rx(input logic [RX_AW-1:0] i);
    if (i == RX_AW'(RX_DEPTH - 1)) begin
      return '0;
    end else begin
      return i + 1'b1;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/uart_ring_buffer_echo_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_ring_buffer_echo_core
// UART byte buffering with receive and transmit rings and poll echo.
// ----------------------------------------------------------------------------
// Each request word takes two steps: one to read the ring slots at the
// next read positions from the two registered-read RAMs, one to
// update the pointers, write the ring and load the result register. A new
// request is taken while the previous result still waits in the output
// register; the block stalls in its update cycle only while that register
// is full. The rings need no clearing after reset. A ring of depth N holds
// at most N-1 bytes; a byte received into a full receive ring overwrites
// the newest slot, and a put or echoing poll into a full transmit ring is
// refused with accepted low.
module uart_ring_buffer_echo_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
  input  wire logic [1:0]  s_tuser,  // [1:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata   // [0] line_valid, [8:1] line_byte,
                                     // [9] deliver_valid, [17:10] deliver_byte,
                                     // [18] accepted, [19] rx_nonempty,
                                     // [20] tx_active, [23:21] zero
);

  urbe_pkg::result_t               res, res_q;
  logic                            res_valid;
  logic                            out_free;
  urbe_pkg::tx_mem_req_t           tx_mem;
  urbe_pkg::rx_mem_req_t           rx_mem;
  logic [urbe_pkg::BYTE_W-1:0]     tx_rdata, rx_rdata;

  assign out_free = !m_tvalid || m_tready;

  urbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .data_byte (s_tdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .tx_mem    (tx_mem),
    .tx_rdata  (tx_rdata),
    .rx_mem    (rx_mem),
    .rx_rdata  (rx_rdata)
  );

  // transmit ring
  urbe_ram #(
    .DEPTH (urbe_pkg::TX_DEPTH),
    .WIDTH (urbe_pkg::BYTE_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_mem.we),
    .waddr (tx_mem.waddr),
    .wdata (tx_mem.wdata),
    .re    (tx_mem.re),
    .raddr (tx_mem.raddr),
    .rdata (tx_rdata)
  );

  // receive ring
  urbe_ram #(
    .DEPTH (urbe_pkg::RX_DEPTH),
    .WIDTH (urbe_pkg::BYTE_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_mem.we),
    .waddr (rx_mem.waddr),
    .wdata (rx_mem.wdata),
    .re    (rx_mem.re),
    .raddr (rx_mem.raddr),
    .rdata (rx_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  // result word packing
  assign m_tdata = {3'b000, res_q};

endmodule
`default_nettype wire

@@ sv/urbe_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urbe_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module urbe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/urbe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urbe_ctrl
// Ring pointer and transmitter state control: reads the ring slots on
// accept, then updates pointers, writes the rings and forms the result.
// ----------------------------------------------------------------------------
module urbe_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [urbe_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          out_free,
  output logic                               res_valid,
  output urbe_pkg::result_t                  res,
  output urbe_pkg::tx_mem_req_t              tx_mem,
  input  wire logic [urbe_pkg::BYTE_W-1:0]   tx_rdata,
  output urbe_pkg::rx_mem_req_t              rx_mem,
  input  wire logic [urbe_pkg::BYTE_W-1:0]   rx_rdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                          state;
  logic [1:0]                    req_q;
  logic [urbe_pkg::BYTE_W-1:0]   data_q;
  logic [urbe_pkg::TX_AW-1:0]    tx_wr, tx_wr_next, tx_rd, tx_rd_next;
  logic [urbe_pkg::RX_AW-1:0]    rx_wr, rx_wr_next, rx_rd, rx_rd_next;
  logic                          tx_busy, tx_busy_next;
  logic                          accept, fire;

  // put path scratch
  logic                          put_en;
  logic [urbe_pkg::BYTE_W-1:0]   put_byte;
  logic                          put_ok;
  logic [urbe_pkg::TX_AW-1:0]    tx_wn;
  logic [urbe_pkg::RX_AW-1:0]    rx_wn;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign fire      = (state == ST_EXEC) && out_free;
  assign res_valid = fire;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_EXEC;
        ST_EXEC: if (fire) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      data_q <= data_byte;
    end
  end

  // pointers and transmitter flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr   <= '0;
      tx_rd   <= '0;
      rx_wr   <= '0;
      rx_rd   <= '0;
      tx_busy <= 1'b0;
    end else if (fire) begin
      tx_wr   <= tx_wr_next;
      tx_rd   <= tx_rd_next;
      rx_wr   <= rx_wr_next;
      rx_rd   <= rx_rd_next;
      tx_busy <= tx_busy_next;
    end
  end

  // request execution
  always_comb begin
    // slot reads for the next pop, issued on accept
    tx_mem.re    = accept;
    tx_mem.raddr = urbe_pkg::next_tx(tx_rd);
    rx_mem.re    = accept;
    rx_mem.raddr = urbe_pkg::next_rx(rx_rd);

    tx_wr_next   = tx_wr;
    tx_rd_next   = tx_rd;
    rx_wr_next   = rx_wr;
    rx_rd_next   = rx_rd;
    tx_busy_next = tx_busy;
    res          = '0;
    res.accepted = 1'b1;
    tx_mem.we    = 1'b0;
    tx_mem.waddr = '0;
    tx_mem.wdata = '0;
    rx_mem.we    = 1'b0;
    rx_mem.waddr = '0;
    rx_mem.wdata = data_q;
    put_en       = 1'b0;
    put_byte     = data_q;
    put_ok       = 1'b1;
    tx_wn        = urbe_pkg::next_tx(tx_wr);
    rx_wn        = urbe_pkg::next_rx(rx_wr);

    case (req_q)
      urbe_pkg::REQ_RX_BYTE: begin
        // full ring overwrites the newest slot
        if (rx_wn != rx_rd) begin
          rx_wr_next = rx_wn;
        end
        rx_mem.we    = fire;
        rx_mem.waddr = rx_wr_next;
      end
      urbe_pkg::REQ_TX_EMPTY: begin
        if (tx_wr != tx_rd) begin
          tx_rd_next    = urbe_pkg::next_tx(tx_rd);
          res.line_valid = 1'b1;
          res.line_byte  = tx_rdata;
        end else begin
          tx_busy_next = 1'b0;
        end
      end
      urbe_pkg::REQ_POLL: begin
        if (rx_wr != rx_rd) begin
          put_en   = (rx_rdata != urbe_pkg::ESC_CODE);
          put_byte = rx_rdata;
        end
      end
      urbe_pkg::REQ_PUT: begin
        put_en = 1'b1;
      end
      default: begin
      end
    endcase

    // put path: straight to the line when idle, else queue, or refuse when the transmit ring is full
    if (put_en) begin
      if (!tx_busy) begin
        tx_busy_next   = 1'b1;
        res.line_valid = 1'b1;
        res.line_byte  = put_byte;
      end else if (tx_wn == tx_rd) begin
        put_ok = 1'b0;
      end else begin
        tx_wr_next   = tx_wn;
        tx_mem.we    = fire;
        tx_mem.waddr = tx_wn;
        tx_mem.wdata = put_byte;
      end
    end

    // pop completes unless the echo was refused
    if (req_q == urbe_pkg::REQ_POLL && rx_wr != rx_rd) begin
      if (put_ok) begin
        rx_rd_next        = urbe_pkg::next_rx(rx_rd);
        res.deliver_valid = 1'b1;
        res.deliver_byte  = rx_rdata;
      end
    end

    res.accepted    = put_ok;
    res.rx_nonempty = (rx_wr_next != rx_rd_next);
    res.tx_active   = tx_busy_next;
  end

endmodule
`default_nettype wire

@@ sv/urbe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urbe_checker
// Port-level checks for the uart ring buffer echo core, bound to the top.
// ----------------------------------------------------------------------------
module urbe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous one in flight");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

  // a refused request sends and delivers nothing
  a_refused: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[18]) |-> (!m_tdata[0] && !m_tdata[9]))
    else $error("refused request produced a byte");

  // a byte to the line leaves the transmitter active
  a_line_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[20])
    else $error("line byte with transmitter idle");

endmodule

bind uart_ring_buffer_echo_core urbe_checker u_urbe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
